// ===== rtl/hrul_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrul_pkg: shared definitions for the HID report usage locator
// Item codes, usage slot sizing and the parse state record with its
// cleared value.
// ----------------------------------------------------------------------------
package hrul_pkg;

  // Usage list sizing
  localparam int USAGE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(USAGE_SLOTS);
  localparam int FILL_W      = $clog2(USAGE_SLOTS + 1);

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam logic REG_TARGET_PAGE  = 1'b0;
  localparam logic REG_TARGET_USAGE = 1'b1;

  // Reset values of the target registers
  localparam logic [15:0] TARGET_PAGE_RESET  = 16'h0001;
  localparam logic [15:0] TARGET_USAGE_RESET = 16'h0030;

  // Short item prefix fields
  localparam logic [1:0] TYPE_MAIN   = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL  = 2'd2;

  localparam logic [3:0] TAG_INPUT        = 4'd8;
  localparam logic [3:0] TAG_COLLECTION   = 4'd10;
  localparam logic [3:0] TAG_USAGE_PAGE   = 4'd0;
  localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
  localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
  localparam logic [3:0] TAG_USAGE        = 4'd0;
  localparam logic [3:0] TAG_USAGE_MIN    = 4'd1;
  localparam logic [3:0] TAG_USAGE_MAX    = 4'd2;

  localparam logic [7:0] LONG_ITEM_PREFIX = 8'hfe;
  localparam logic [7:0] CODE_NOT_FOUND   = 8'hff;
  localparam logic [31:0] RANGE_MIN_CLEAR = 32'd65535;

  // Parse state kept in flip-flops (the usage values live in a RAM)
  typedef struct packed {
    logic                   data_phase;
    logic [2:0]             bytes_left;
    logic [1:0]             byte_idx;
    logic [7:0]             prefix;
    logic [31:0]            value;
    logic [31:0]            page;
    logic [7:0]             field_size;
    logic [7:0]             field_count;
    logic [15:0]            bit_pos;
    logic [USAGE_SLOTS-1:0] slot_valid;
    logic [FILL_W-1:0]      fill;
    logic [31:0]            range_min;
    logic [31:0]            range_max;
    logic                   range_max_neg;
    logic [7:0]             match_code;
    logic                   matched;
    logic                   overflow;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{
    data_phase:    1'b0,
    bytes_left:    3'd0,
    byte_idx:      2'd0,
    prefix:        8'd0,
    value:         32'd0,
    page:          32'd0,
    field_size:    8'd0,
    field_count:   8'd0,
    bit_pos:       16'd0,
    slot_valid:    '0,
    fill:          '0,
    range_min:     RANGE_MIN_CLEAR,
    range_max:     32'd0,
    range_max_neg: 1'b1,
    match_code:    CODE_NOT_FOUND,
    matched:       1'b0,
    overflow:      1'b0
  };

  // Number of data bytes that follow a prefix
  function automatic logic [2:0] data_len(input logic [7:0] prefix);
    logic [2:0] len;
    len = (prefix[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix[1:0]};
    return len;
  endfunction

endpackage : hrul_pkg
`default_nettype wire

// ===== rtl/hrul_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrul_if: request channels of the HID report usage locator
// Descriptor byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hrul_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       last_byte;

  modport source (output valid, output desc_byte, output last_byte, input ready);
  modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface : hrul_in_if

interface hrul_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [7:0] position_code;
  logic       usage_overflow;

  modport source (output valid, output found, output position_code,
                  output usage_overflow, input ready);
  modport sink   (input valid, input found, input position_code,
                  input usage_overflow, output ready);
endinterface : hrul_out_if
`default_nettype wire

// ===== rtl/hrul_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrul_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hrul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : hrul_ram
`default_nettype wire

// ===== rtl/hid_report_usage_locator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hid_report_usage_locator: find a usage in a HID report descriptor
// Parses short items of a report descriptor byte by byte and reports where
// the last Input field carrying the target page and usage sits in the report.
// ----------------------------------------------------------------------------
// Descriptor bytes are taken one per cycle whenever the parser is idle. Most
// items finish in the cycle of their last byte. An Input item walks its
// fields through the usage RAM after its last byte, each field with a read,
// then a compare. Every Usage Minimum or Maximum goes through a range check;
// one that opens a valid range then writes one RAM slot per cycle, up to 16
// slots. After the byte marked last, once the output register is free, the
// result register is loaded and the parser cleared; the next descriptor may
// start while the result still waits to be taken. No clearing pass is needed
// after reset: the usage slots carry valid bits.
module hid_report_usage_locator
  import hrul_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  hrul_in_if.sink                    in_chan,
  hrul_out_if.source                 out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_WALK_RD    = 6'b000010,
    S_WALK_CMP   = 6'b000100,
    S_RANGE_CHK  = 6'b001000,
    S_RANGE_FILL = 6'b010000,
    S_DONE       = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  parse_t              ps_r, ps_nxt;
  logic                last_pend_r, last_pend_nxt;
  logic [7:0]          j_r, j_nxt;
  logic [SLOT_W-1:0]   span_last_r, span_last_nxt;
  logic [15:0]         tgt_page_r, tgt_page_nxt;
  logic [15:0]         tgt_usage_r, tgt_usage_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [7:0]          out_code_r, out_code_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // RAM ports
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [31:0]         ram_wdata;
  logic [31:0]         ram_rdata;

  // Item decode helpers
  logic                item_done;
  logic [7:0]          cur_prefix;
  logic [31:0]         cur_value;
  logic [FILL_W-1:0]   fill_inc;
  state_t              exit_state;

  // Field walk helpers
  logic [15:0]         bp_new;
  logic [15:0]         bp_less;
  logic [2:0]          bit_k;
  logic [7:0]          byte_b;
  logic [31:0]         slot_usage;
  logic                slot_live;

  // Range check helpers
  logic [32:0]         range_diff;
  logic                range_open;

  hrul_ram #(
    .WIDTH (32),
    .DEPTH (USAGE_SLOTS)
  ) u_usage_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (j_r[SLOT_W-1:0]),
    .rd_data (ram_rdata)
  );

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_USAGE) ? {16'd0, tgt_usage_r}
                                                  : {16'd0, tgt_page_r};

  always_comb begin
    tgt_page_nxt  = tgt_page_r;
    tgt_usage_nxt = tgt_usage_r;
    if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TARGET_PAGE:  tgt_page_nxt  = pwdata[15:0];
        REG_TARGET_USAGE: tgt_usage_nxt = pwdata[15:0];
        default:          tgt_page_nxt  = tgt_page_r;
      endcase
    end
  end

  // Channel ports
  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.position_code = out_code_r;
  assign out_chan.usage_overflow = out_ovf_r;

  // Field position arithmetic
  assign bp_new     = ps_r.bit_pos + {8'd0, ps_r.field_size};
  assign bp_less    = bp_new - 16'd1;
  assign bit_k      = bp_less[2:0];
  assign byte_b     = bp_new[10:3];
  assign slot_live  = (j_r < 8'(USAGE_SLOTS)) && ps_r.slot_valid[j_r[SLOT_W-1:0]];
  assign slot_usage = slot_live ? ram_rdata : 32'd0;

  // Usage range check
  assign range_diff = {1'b0, ps_r.range_max} - {1'b0, ps_r.range_min};
  assign range_open = !ps_r.range_max_neg && !range_diff[32] && (range_diff != 33'd0);

  assign fill_inc   = (ps_r.fill < FILL_W'(USAGE_SLOTS)) ? ps_r.fill + FILL_W'(1)
                                                        : ps_r.fill;
  assign exit_state = last_pend_r ? S_DONE : S_IDLE;

  // Byte assembly of the current item
  always_comb begin
    item_done  = 1'b0;
    cur_prefix = ps_r.prefix;
    cur_value  = ps_r.value;
    if (!ps_r.data_phase) begin
      cur_prefix = in_chan.desc_byte;
      cur_value  = 32'd0;
      item_done  = (data_len(in_chan.desc_byte) == 3'd0);
    end else begin
      cur_value  = ps_r.value | ({24'd0, in_chan.desc_byte} << {ps_r.byte_idx, 3'b000});
      item_done  = (ps_r.bytes_left == 3'd1);
    end
  end

  // Parser sequencer
  always_comb begin
    state_nxt     = state_r;
    ps_nxt        = ps_r;
    last_pend_nxt = last_pend_r;
    j_nxt         = j_r;
    span_last_nxt = span_last_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_code_nxt  = out_code_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = ps_r.fill[SLOT_W-1:0];
    ram_wdata     = cur_value;

    // Drop the result once taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          last_pend_nxt = in_chan.last_byte;
          state_nxt     = in_chan.last_byte ? S_DONE : S_IDLE;
          // Assemble prefix and data bytes
          if (!ps_r.data_phase) begin
            ps_nxt.prefix     = in_chan.desc_byte;
            ps_nxt.value      = 32'd0;
            ps_nxt.byte_idx   = 2'd0;
            ps_nxt.bytes_left = data_len(in_chan.desc_byte);
            ps_nxt.data_phase = !item_done;
          end else begin
            ps_nxt.value      = cur_value;
            ps_nxt.byte_idx   = ps_r.byte_idx + 2'd1;
            ps_nxt.bytes_left = ps_r.bytes_left - 3'd1;
            ps_nxt.data_phase = !item_done;
          end
          // Act on a completed short item
          if (item_done && (cur_prefix != LONG_ITEM_PREFIX)) begin
            case (cur_prefix[3:2])
              TYPE_MAIN: begin
                if (cur_prefix[7:4] == TAG_INPUT) begin
                  j_nxt     = 8'd0;
                  state_nxt = S_WALK_RD;
                end else if (cur_prefix[7:4] == TAG_COLLECTION) begin
                  ps_nxt.fill = '0;
                end
              end
              TYPE_GLOBAL: begin
                case (cur_prefix[7:4])
                  TAG_USAGE_PAGE:   ps_nxt.page        = cur_value;
                  TAG_REPORT_SIZE:  ps_nxt.field_size  = cur_value[7:0];
                  TAG_REPORT_COUNT: ps_nxt.field_count = cur_value[7:0];
                  TAG_REPORT_ID:    ps_nxt.bit_pos     = ps_r.bit_pos + 16'd8;
                  default:          ps_nxt.page        = ps_r.page;
                endcase
              end
              TYPE_LOCAL: begin
                case (cur_prefix[7:4])
                  TAG_USAGE: begin
                    if (ps_r.fill < FILL_W'(USAGE_SLOTS)) begin
                      ram_we = 1'b1;
                      ps_nxt.slot_valid[ps_r.fill[SLOT_W-1:0]] = 1'b1;
                    end
                    ps_nxt.fill = fill_inc;
                    if (fill_inc == FILL_W'(USAGE_SLOTS)) begin
                      ps_nxt.overflow = 1'b1;
                    end
                  end
                  TAG_USAGE_MIN: begin
                    ps_nxt.range_min = cur_value;
                    state_nxt        = S_RANGE_CHK;
                  end
                  TAG_USAGE_MAX: begin
                    ps_nxt.range_max     = cur_value;
                    ps_nxt.range_max_neg = 1'b0;
                    state_nxt            = S_RANGE_CHK;
                  end
                  default: ps_nxt.fill = ps_r.fill;
                endcase
              end
              default: ps_nxt.fill = ps_r.fill;
            endcase
          end
        end
      end

      S_WALK_RD: begin
        if (j_r == ps_r.field_count) begin
          // Input done: clear the local usage state
          ps_nxt.slot_valid    = '0;
          ps_nxt.fill          = '0;
          ps_nxt.range_min     = RANGE_MIN_CLEAR;
          ps_nxt.range_max_neg = 1'b1;
          state_nxt            = exit_state;
        end else begin
          state_nxt = S_WALK_CMP;
        end
      end

      S_WALK_CMP: begin
        // Advance one field and compare its usage
        ps_nxt.bit_pos = bp_new;
        if ((ps_r.page == {16'd0, tgt_page_r}) && (slot_usage == {16'd0, tgt_usage_r})) begin
          ps_nxt.matched    = 1'b1;
          ps_nxt.match_code = (bit_k == 3'd7) ? byte_b - 8'd1
                                              : byte_b | {1'b0, bit_k, 4'b0000};
        end
        j_nxt     = j_r + 8'd1;
        state_nxt = S_WALK_RD;
      end

      S_RANGE_CHK: begin
        if (range_open) begin
          j_nxt = 8'd0;
          if (range_diff[31:0] >= 32'(USAGE_SLOTS - 1)) begin
            span_last_nxt   = SLOT_W'(USAGE_SLOTS - 1);
            ps_nxt.fill     = FILL_W'(USAGE_SLOTS);
            ps_nxt.overflow = 1'b1;
          end else begin
            span_last_nxt = range_diff[SLOT_W-1:0];
            ps_nxt.fill   = FILL_W'(range_diff[SLOT_W-1:0]) + FILL_W'(1);
          end
          state_nxt = S_RANGE_FILL;
        end else begin
          state_nxt = exit_state;
        end
      end

      S_RANGE_FILL: begin
        // Write one range value per cycle
        ram_we    = 1'b1;
        ram_waddr = j_r[SLOT_W-1:0];
        ram_wdata = ps_r.range_min + {24'd0, j_r};
        ps_nxt.slot_valid[j_r[SLOT_W-1:0]] = 1'b1;
        if (j_r[SLOT_W-1:0] == span_last_r) begin
          state_nxt = exit_state;
        end else begin
          j_nxt = j_r + 8'd1;
        end
      end

      S_DONE: begin
        // Load the result when the output register is free, then clear
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = ps_r.matched;
          out_code_nxt  = ps_r.matched ? ps_r.match_code : CODE_NOT_FOUND;
          out_ovf_nxt   = ps_r.overflow;
          ps_nxt        = PARSE_CLEAR;
          last_pend_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ps_r        <= PARSE_CLEAR;
      last_pend_r <= 1'b0;
      j_r         <= 8'd0;
      tgt_page_r  <= TARGET_PAGE_RESET;
      tgt_usage_r <= TARGET_USAGE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ps_r        <= ps_nxt;
      last_pend_r <= last_pend_nxt;
      j_r         <= j_nxt;
      tgt_page_r  <= tgt_page_nxt;
      tgt_usage_r <= tgt_usage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    span_last_r <= span_last_nxt;
    out_found_r <= out_found_nxt;
    out_code_r  <= out_code_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

`ifndef SYNTHESIS
  // Fill count never passes the slot count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ps_r.fill <= FILL_W'(USAGE_SLOTS))
    else $error("usage fill count beyond slot count");

  // A full usage list has always raised the overflow flag
  a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ps_r.fill == FILL_W'(USAGE_SLOTS)) |-> ps_r.overflow)
    else $error("usage list full without overflow flag");

  // A compare always follows the RAM read of the same slot
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_CMP) |-> ($past(state_r) == S_WALK_RD) && $stable(j_r))
    else $error("field compare without matching RAM read");

  // A result without a match carries the not-found code
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_code_r == CODE_NOT_FOUND))
    else $error("not-found result with a position code");
`endif

endmodule : hid_report_usage_locator
`default_nettype wire
